>>> design/csxt_pkg.sv
// csxt_pkg: shared types, codes and constants of the call-stack exclusive-time profiler
// no dependencies; used by every module of the block
package csxt_pkg;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned FuncIdW  = 6;
  localparam int unsigned TsW      = 31;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned TotalW   = 48;
  localparam int unsigned DurW     = 32;
  localparam int unsigned FcW      = 7;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  // number of ids that the id field can name
  localparam int unsigned FuncIds = 2 ** FuncIdW;

  // parameter defaults
  localparam int unsigned MaxFuncsDef   = 64;
  localparam int unsigned StackDepthDef = 64;

  // register reset value and saturation limits
  localparam logic [FcW-1:0] FcReset = 7'd64;
  localparam logic signed [TotalW-1:0] TotalMax = {1'b0, {(TotalW-1){1'b1}}};
  localparam logic signed [TotalW-1:0] TotalMin = {1'b1, {(TotalW-1){1'b0}}};

  // register indexes
  localparam logic [0:0] RegFunctionCount = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_START = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_TOTAL_OVF = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_END_POP,
    S_END_TOP,
    S_END_SUB,
    S_RD_CLR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]     operation;
    logic [FuncIdW-1:0] function_id;
    logic [TsW-1:0]     timestamp;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0]        status;
    logic signed [TotalW-1:0]  total;
    logic [DurW-1:0]           duration;
  } out_t;

  typedef struct packed {
    logic [FuncIdW-1:0] id;
    logic [TsW-1:0]     start;
  } stk_entry_t;

endpackage

>>> design/csxt_cfg.sv
// csxt_cfg: apb register block holding function_count
// depends on csxt_pkg
module csxt_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [csxt_pkg::ApbAddrW-1:0]      paddr,
  input  logic [csxt_pkg::ApbDataW-1:0]      pwdata,
  output logic [csxt_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  output logic [csxt_pkg::FcW-1:0]           fc_o
);

  logic [csxt_pkg::FcW-1:0] fc_q, fc_d;
  logic                     wr_en;

  // write strobe on the access phase
  assign wr_en = psel && penable && pwrite && pready &&
                 (paddr[2] == csxt_pkg::RegFunctionCount);

  always_comb begin
    fc_d = fc_q;
    if (wr_en) begin
      fc_d = pwdata[csxt_pkg::FcW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= csxt_pkg::FcReset;
    end else begin
      fc_q <= fc_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == csxt_pkg::RegFunctionCount) begin
      prdata = {{(csxt_pkg::ApbDataW-csxt_pkg::FcW){1'b0}}, fc_q};
    end
  end

  assign pready = 1'b1;
  assign fc_o   = fc_q;

endmodule

>>> design/csxt_stack_mem.sv
// csxt_stack_mem: call stack storage, one write and one registered read per cycle
// depends on csxt_pkg
module csxt_stack_mem #(
  parameter int unsigned Depth = csxt_pkg::StackDepthDef
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  csxt_pkg::stk_entry_t       wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output csxt_pkg::stk_entry_t       rdata_o
);

  csxt_pkg::stk_entry_t mem [Depth];
  csxt_pkg::stk_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/csxt_total_mem.sv
// csxt_total_mem: exclusive-time totals, one write and one registered read per cycle
// per-entry valid bits make unwritten entries read as zero; depends on csxt_pkg
module csxt_total_mem #(
  parameter int unsigned Depth = csxt_pkg::MaxFuncsDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [AddrW-1:0]                     waddr_i,
  input  logic signed [csxt_pkg::TotalW-1:0]   wdata_i,
  input  logic                                 re_i,
  input  logic [AddrW-1:0]                     raddr_i,
  output logic signed [csxt_pkg::TotalW-1:0]   rdata_o
);

  logic signed [csxt_pkg::TotalW-1:0] mem [Depth];
  logic signed [csxt_pkg::TotalW-1:0] rdata_q;
  logic [Depth-1:0]                   vld_q;
  logic                               rvld_q;

  // data array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

>>> design/csxt_ctrl.sv
// csxt_ctrl: sequencer for start, end and read beats; read-modify-write of totals
// drives the stack and totals memories; depends on csxt_pkg
module csxt_ctrl #(
  parameter int unsigned MaxFuncs   = csxt_pkg::MaxFuncsDef,
  parameter int unsigned StackDepth = csxt_pkg::StackDepthDef,
  parameter int unsigned TotDepth   = csxt_pkg::FuncIds,
  parameter int unsigned TotAddrW   = (TotDepth > 1) ? $clog2(TotDepth) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [csxt_pkg::FcW-1:0]             fc_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  csxt_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output csxt_pkg::out_t                       out_data_o,
  // stack memory
  output logic                                 stk_we_o,
  output logic [$clog2(StackDepth)-1:0]        stk_waddr_o,
  output csxt_pkg::stk_entry_t                 stk_wdata_o,
  output logic                                 stk_re_o,
  output logic [$clog2(StackDepth)-1:0]        stk_raddr_o,
  input  csxt_pkg::stk_entry_t                 stk_rdata_i,
  // totals memory
  output logic                                 tot_we_o,
  output logic [TotAddrW-1:0]                  tot_waddr_o,
  output logic signed [csxt_pkg::TotalW-1:0]   tot_wdata_o,
  output logic                                 tot_re_o,
  output logic [TotAddrW-1:0]                  tot_raddr_o,
  input  logic signed [csxt_pkg::TotalW-1:0]   tot_rdata_i
);

  localparam int unsigned SAddrW = $clog2(StackDepth);
  localparam int unsigned CntW   = $clog2(StackDepth + 1);
  localparam int unsigned SumW   = csxt_pkg::TotalW + 1;

  csxt_pkg::state_e state_q, state_d;

  logic [CntW-1:0]                   count_q, count_d;
  logic [csxt_pkg::FuncIdW-1:0]      id_q, id_d;
  logic [csxt_pkg::FuncIdW-1:0]      top_q, top_d;
  logic [csxt_pkg::TsW-1:0]          ts_q, ts_d;
  logic [csxt_pkg::DurW-1:0]         dur_q, dur_d;
  csxt_pkg::out_t                    res_q, res_d;
  csxt_pkg::out_t                    out_q, out_d;
  logic                              out_valid_q, out_valid_d;

  logic                              in_fire;
  logic                              id_ok;
  logic                              stack_empty;
  logic                              stack_full;
  logic                              slot_free;
  logic                              done;
  logic                              go_pop;
  logic                              go_rd;
  logic [csxt_pkg::TsW-1:0]          start_ts;
  logic [csxt_pkg::DurW-1:0]         diff;
  logic signed [SumW-1:0]            sum_add;
  logic signed [SumW-1:0]            sum_sub;
  logic signed [csxt_pkg::TotalW-1:0] sub_base;
  logic                              add_ovf;
  logic                              sub_ovf;
  logic signed [csxt_pkg::TotalW-1:0] add_val;
  logic signed [csxt_pkg::TotalW-1:0] sub_val;

  // input decode
  assign in_ready_o  = (state_q == csxt_pkg::S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign id_ok       = ({1'b0, in_data_i.function_id} < fc_i) &&
                       (int'(in_data_i.function_id) < MaxFuncs);
  assign stack_empty = (count_q == '0);
  assign stack_full  = (count_q == CntW'(StackDepth));
  assign slot_free   = !out_valid_q || out_ready_i;
  assign go_pop      = id_ok && !stack_empty &&
                       (in_data_i.operation == csxt_pkg::OP_END);
  assign go_rd       = id_ok && (in_data_i.operation == csxt_pkg::OP_READ);

  // result available this cycle
  always_comb begin
    done = 1'b0;
    unique case (state_q)
      csxt_pkg::S_IDLE:    done = in_fire && !go_pop && !go_rd;
      csxt_pkg::S_END_POP: done = 1'b0;
      csxt_pkg::S_END_TOP: done = stack_empty;
      csxt_pkg::S_END_SUB: done = 1'b1;
      csxt_pkg::S_RD_CLR:  done = 1'b1;
      csxt_pkg::S_EMIT:    done = 1'b1;
      default:             done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    if (done) begin
      state_d = slot_free ? csxt_pkg::S_IDLE : csxt_pkg::S_EMIT;
    end else begin
      unique case (state_q)
        csxt_pkg::S_IDLE: begin
          if (in_fire && go_pop) begin
            state_d = csxt_pkg::S_END_POP;
          end else if (in_fire && go_rd) begin
            state_d = csxt_pkg::S_RD_CLR;
          end
        end
        csxt_pkg::S_END_POP: state_d = csxt_pkg::S_END_TOP;
        csxt_pkg::S_END_TOP: state_d = csxt_pkg::S_END_SUB;
        default:             state_d = state_q;
      endcase
    end
  end

  // duration and saturating total arithmetic
  assign start_ts = stk_rdata_i.start;
  assign diff     = csxt_pkg::DurW'(ts_q) - csxt_pkg::DurW'(start_ts) + 1'b1;
  assign sum_add  = {tot_rdata_i[csxt_pkg::TotalW-1], tot_rdata_i} +
                    SumW'({1'b0, dur_q});
  assign add_ovf  = sum_add[SumW-1] ^ sum_add[SumW-2];
  assign add_val  = add_ovf ? csxt_pkg::TotalMax : sum_add[csxt_pkg::TotalW-1:0];
  // a caller equal to the ending id sees the total just written
  assign sub_base = (top_q == id_q) ? res_q.total : tot_rdata_i;
  assign sum_sub  = {sub_base[csxt_pkg::TotalW-1], sub_base} -
                    SumW'({1'b0, dur_q});
  assign sub_ovf  = sum_sub[SumW-1] ^ sum_sub[SumW-2];
  assign sub_val  = sub_ovf ? csxt_pkg::TotalMin : sum_sub[csxt_pkg::TotalW-1:0];

  // datapath and memory controls
  always_comb begin
    count_d     = count_q;
    id_d        = id_q;
    top_d       = top_q;
    ts_d        = ts_q;
    dur_d       = dur_q;
    res_d       = res_q;
    stk_we_o    = 1'b0;
    stk_waddr_o = SAddrW'(count_q);
    stk_wdata_o = '{id: in_data_i.function_id, start: in_data_i.timestamp};
    stk_re_o    = 1'b0;
    stk_raddr_o = SAddrW'(count_q - 1'b1);
    tot_we_o    = 1'b0;
    tot_waddr_o = TotAddrW'(id_q);
    tot_wdata_o = '0;
    tot_re_o    = 1'b0;
    tot_raddr_o = TotAddrW'(in_data_i.function_id);
    unique case (state_q)
      csxt_pkg::S_IDLE: begin
        res_d = '0;
        id_d  = in_data_i.function_id;
        ts_d  = in_data_i.timestamp;
        if (in_fire) begin
          unique case (csxt_pkg::op_e'(in_data_i.operation))
            csxt_pkg::OP_START: begin
              if (!id_ok) begin
                res_d.status = csxt_pkg::ST_BAD_ID;
              end else if (stack_full) begin
                res_d.status = csxt_pkg::ST_OVERFLOW;
              end else begin
                stk_we_o = 1'b1;
                count_d  = count_q + 1'b1;
              end
            end
            csxt_pkg::OP_END: begin
              if (!id_ok) begin
                res_d.status = csxt_pkg::ST_BAD_ID;
              end else if (stack_empty) begin
                res_d.status = csxt_pkg::ST_UNDERFLOW;
              end else begin
                stk_re_o = 1'b1;
                tot_re_o = 1'b1;
                count_d  = count_q - 1'b1;
              end
            end
            csxt_pkg::OP_READ: begin
              if (!id_ok) begin
                res_d.status = csxt_pkg::ST_BAD_ID;
              end else begin
                tot_re_o = 1'b1;
              end
            end
            default: res_d = '0;
          endcase
        end
      end
      csxt_pkg::S_END_POP: begin
        // popped entry's start time is here; fetch the new top entry
        dur_d = (ts_q >= start_ts) ? diff : '0;
        if (!stack_empty) begin
          stk_re_o = 1'b1;
        end
      end
      csxt_pkg::S_END_TOP: begin
        tot_we_o          = 1'b1;
        tot_wdata_o       = add_val;
        res_d.status      = add_ovf ? csxt_pkg::ST_TOTAL_OVF : csxt_pkg::ST_OK;
        res_d.total       = add_val;
        res_d.duration    = dur_q;
        top_d             = stk_rdata_i.id;
        if (!stack_empty) begin
          tot_re_o    = 1'b1;
          tot_raddr_o = TotAddrW'(stk_rdata_i.id);
        end
      end
      csxt_pkg::S_END_SUB: begin
        tot_we_o    = 1'b1;
        tot_waddr_o = TotAddrW'(top_q);
        tot_wdata_o = sub_val;
        if (sub_ovf) begin
          res_d.status = csxt_pkg::ST_TOTAL_OVF;
        end
        if (top_q == id_q) begin
          res_d.total = sub_val;
        end
      end
      csxt_pkg::S_RD_CLR: begin
        tot_we_o = 1'b1;
        res_d    = '{status: csxt_pkg::ST_OK, total: tot_rdata_i, duration: '0};
      end
      csxt_pkg::S_EMIT: res_d = res_q;
      default:          res_d = res_q;
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (done && slot_free) begin
      out_d       = res_d;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csxt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    top_q <= top_d;
    ts_q  <= ts_d;
    dur_q <= dur_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/call_stack_exclusive_time_profiler_core.sv
// call_stack_exclusive_time_profiler_core: top level of the exclusive-time profiler
// start, bad id, underflow and unused codes finish in S_IDLE, a read in S_RD_CLR, an end
// in S_END_POP and S_END_TOP, then in S_END_SUB unless the stack is empty after the pop;
// a stalled result waits in S_EMIT; one beat at a time, a new one taken only in S_IDLE
// (stack and totals memories have one read port each)
// reset: stack empty, all totals zero at once via valid bits, function_count 64
// depends on csxt_pkg, csxt_cfg, csxt_stack_mem, csxt_total_mem, csxt_ctrl
module call_stack_exclusive_time_profiler_core #(
  parameter int unsigned MaxFuncs   = csxt_pkg::MaxFuncsDef,
  parameter int unsigned StackDepth = csxt_pkg::StackDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  csxt_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output csxt_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csxt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [csxt_pkg::ApbDataW-1:0]  pwdata,
  output logic [csxt_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned TotDepth = (MaxFuncs < csxt_pkg::FuncIds) ?
                                     MaxFuncs : csxt_pkg::FuncIds;
  localparam int unsigned TotAddrW = (TotDepth > 1) ? $clog2(TotDepth) : 1;
  localparam int unsigned SAddrW   = $clog2(StackDepth);

  logic [csxt_pkg::FcW-1:0]            fc;
  logic                                stk_we;
  logic [SAddrW-1:0]                   stk_waddr;
  csxt_pkg::stk_entry_t                stk_wdata;
  logic                                stk_re;
  logic [SAddrW-1:0]                   stk_raddr;
  csxt_pkg::stk_entry_t                stk_rdata;
  logic                                tot_we;
  logic [TotAddrW-1:0]                 tot_waddr;
  logic signed [csxt_pkg::TotalW-1:0]  tot_wdata;
  logic                                tot_re;
  logic [TotAddrW-1:0]                 tot_raddr;
  logic signed [csxt_pkg::TotalW-1:0]  tot_rdata;

  // configuration registers
  csxt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .fc_o    (fc)
  );

  // call stack storage
  csxt_stack_mem #(
    .Depth (StackDepth)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // totals storage
  csxt_total_mem #(
    .Depth (TotDepth),
    .AddrW (TotAddrW)
  ) u_total_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  // sequencer
  csxt_ctrl #(
    .MaxFuncs   (MaxFuncs),
    .StackDepth (StackDepth),
    .TotDepth   (TotDepth),
    .TotAddrW   (TotAddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fc_i        (fc),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_re_o    (stk_re),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata),
    .tot_we_o    (tot_we),
    .tot_waddr_o (tot_waddr),
    .tot_wdata_o (tot_wdata),
    .tot_re_o    (tot_re),
    .tot_raddr_o (tot_raddr),
    .tot_rdata_i (tot_rdata)
  );

endmodule
